FILE: rtl/core/bsa_pkg.sv
// shared types, constants and helper functions of the bitmap slot allocator
`default_nettype none
package bsa_pkg;

	localparam int SLOTS     = 256;
	localparam int WORD_W    = 64;
	localparam int BIT_W     = 6;
	localparam int SLOT_W    = 8;
	localparam int MAP_WORDS = SLOTS / WORD_W;
	localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] slot_out;
	} rsp_t;

	typedef struct packed {
		logic             full;
		logic [BIT_W-1:0] bit_pos;
	} scan_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK,
		ST_DONE
	} state_t;

	// map word that holds a slot, truncated to the address width
	function automatic logic [WORD_AW-1:0] slot_word(input logic [SLOT_W-1:0] slot);
		logic [15:0] w;
		begin
			w = 16'(slot[SLOT_W-1:BIT_W]);
			return w[WORD_AW-1:0];
		end
	endfunction

	// slot lies inside the map
	function automatic logic slot_in_map(input logic [SLOT_W-1:0] slot);
		begin
			return 16'(slot[SLOT_W-1:BIT_W]) < 16'(MAP_WORDS);
		end
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bsa_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none
module bsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/bsa_scan.sv
// lowest clear bit finder for one map word
`default_nettype none
module bsa_scan
	import bsa_pkg::*;
(
	input  wire logic [WORD_W-1:0] map_word,
	output scan_t                  scan
);

	logic [WORD_W-1:0] first_zero;
	logic [BIT_W-1:0]  pos;

	// isolate the lowest zero as a one-hot word
	assign first_zero = ~map_word & (map_word + WORD_W'(1));

	always_comb begin
		pos = '0;
		for (int i = 0; i < WORD_W; i++) begin
			pos = pos | (first_zero[i] ? BIT_W'(i) : '0);
		end
	end

	assign scan.full    = &map_word;
	assign scan.bit_pos = pos;

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_slot_allocator.sv
// top level of the bitmap slot allocator: control sequencer, map ram and scan unit
`default_nettype none
// The allocator keeps one bit per slot (1 taken, 0 free) in SLOTS/64 map words
// of 64 bits stored in a single ram, all free after reset. Per-word valid flops
// make the map read as zero until a word is first written, so no clearing pass
// is needed and a request can be taken as soon as reset is released. An
// allocate reads map words from word 0 upward, one word per cycle through the
// single ram read port, sets the lowest clear bit of the first word that has
// one and returns word*64+bit (low 8 bits); with every slot taken it returns
// status 1 and slot 0 and leaves the map alone. A release clears the bit of
// slot_index (ignored when that slot is past the map) and echoes slot_index.
// One word is worked on at a time: an accepted request has its map word read
// and then checked, and an allocate goes on to read the next word while each
// word read is full (1 to SLOTS/64 words read). A finished result waits until
// the output register is free, and only then is the next request taken.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits on rsp_stall.
module bitmap_slot_allocator
	import bsa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// sequencer state
	state_t state_q, state_d;

	// word under work
	logic               func_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [WORD_AW-1:0] word_q;
	logic               vld_s1;
	rsp_t               res_q;

	// map word valid flops, cleared at reset
	logic [MAP_WORDS-1:0] vld_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// ram ports
	logic               rd_en, wr_en;
	logic [WORD_AW-1:0] rd_addr;
	logic [WORD_W-1:0]  rd_data, wr_data, cur_word;

	// control decode
	logic               accept, rsp_free, last_word, res_load, rsp_load;
	rsp_t               res_d;
	scan_t              scan;
	logic [WORD_AW+BIT_W-1:0] slot_num;

	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign last_word = (word_q == WORD_AW'(MAP_WORDS - 1));
	assign cur_word  = vld_s1 ? rd_data : '0;
	assign slot_num  = {word_q, scan.bit_pos};

	bsa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (word_q),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bsa_scan u_scan (
		.map_word (cur_word),
		.scan     (scan)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				// keep scanning only while allocating through full words
				if (func_q == FUNC_RELEASE || !scan.full || last_word) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = word_q + WORD_AW'(1);
		wr_en     = 1'b0;
		wr_data   = cur_word;
		res_load  = 1'b0;
		res_d     = '{status: STATUS_DONE, slot_out: slot_q};
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				rd_en     = accept;
				// release reads its own word, allocate starts at word 0
				rd_addr   = (req.func == FUNC_RELEASE) ? slot_word(req.slot_index) : '0;
			end
			ST_CHK: begin
				res_load = (state_d == ST_DONE);
				if (func_q == FUNC_RELEASE) begin
					wr_en   = slot_in_map(slot_q);
					wr_data = cur_word & ~(WORD_W'(1) << slot_q[BIT_W-1:0]);
				end else if (!scan.full) begin
					wr_en   = 1'b1;
					wr_data = cur_word | (WORD_W'(1) << scan.bit_pos);
					res_d   = '{status: STATUS_DONE, slot_out: SLOT_W'(slot_num)};
				end else if (last_word) begin
					res_d = '{status: STATUS_FULL, slot_out: '0};
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_DONE: begin
				rsp_load = rsp_free;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				vld_q[word_q] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			slot_q <= req.slot_index;
		end
		if (rd_en) begin
			word_q <= rd_addr;
			vld_s1 <= vld_q[rd_addr];
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// map is written only while a word is checked
	a_wr_in_chk: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_CHK)
		else $error("map write outside check state");

	// a word is never read and written in the same cycle
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("map read and write overlap");

	// an accepted request always goes to the check state
	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CHK)
		else $error("accepted request not checked");

	// a finished result reaches the output register once it is free
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rsp_free) |=> (rsp_valid_q && state_q == ST_IDLE))
		else $error("result not delivered");

endmodule
`default_nettype wire

FILE: tb/bitmap_slot_allocator_test.sv
// self-checking testbench for the bitmap slot allocator: directed plan, random mix, map predictor
`default_nettype none
module bitmap_slot_allocator_test;
	import bsa_pkg::*;

	localparam int ITEMS        = 1350;  // stimulus stops after this many accepted words
	localparam int HOLD_CYCLES  = 80;    // one long receiver hold-off to back up the block
	localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake before giving up
	localparam int DRAIN_CYCLES = 12;    // quiet time after the last result, longer than the slowest allocate
	localparam int PLAN_ROWS    = 25;

	// one row of the directed plan; want is only used when typed is set
	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot;
		logic [8:0]        count;
		logic              typed;
		rsp_t              want;
	} step_t;

	// sender mixes for the random part
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_FLOW,
		RX_RANDOM,
		RX_ALTERNATE,
		RX_HEAVY
	} rx_mode_t;

	// directed plan: corner slots, word boundaries, release of free slots, and the
	// full map (the long allocate run fills all 256 slots, its last word hits full)
	localparam step_t PLAN [PLAN_ROWS] = '{
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b1, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b1, '{STATUS_DONE, 8'd1}},
		'{FUNC_ALLOC,   8'd255, 9'd1,   1'b1, '{STATUS_DONE, 8'd2}},
		'{FUNC_RELEASE, 8'd1,   9'd1,   1'b1, '{STATUS_DONE, 8'd1}},
		'{FUNC_RELEASE, 8'd255, 9'd1,   1'b1, '{STATUS_DONE, 8'd255}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_RELEASE, 8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd0,   9'd256, 1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b1, '{STATUS_FULL, 8'd0}},
		'{FUNC_RELEASE, 8'd255, 9'd1,   1'b1, '{STATUS_DONE, 8'd255}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd255, 9'd1,   1'b1, '{STATUS_FULL, 8'd0}},
		'{FUNC_RELEASE, 8'd63,  9'd1,   1'b1, '{STATUS_DONE, 8'd63}},
		'{FUNC_RELEASE, 8'd64,  9'd1,   1'b1, '{STATUS_DONE, 8'd64}},
		'{FUNC_RELEASE, 8'd127, 9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_RELEASE, 8'd128, 9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_RELEASE, 8'h55,  9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_RELEASE, 8'hAA,  9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_RELEASE, 8'h55,  9'd1,   1'b1, '{STATUS_DONE, 8'h55}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}},
		'{FUNC_ALLOC,   8'd0,   9'd1,   1'b0, '{STATUS_DONE, 8'd0}}
	};

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// predictor state: one bit per slot, 1 taken, all free after reset
	logic [WORD_W-1:0] slot_bits [MAP_WORDS] = '{default: '0};
	rsp_t              results_due [$];
	int                mismatches   = 0;
	int                items_sent   = 0;
	int                burst_left   = 0;
	int                quiet_cycles = 0;
	logic              hold_req     = 1'b0;  // raised once by the sender side
	logic              hold_taken   = 1'b0;  // owned by the receiver process

	bitmap_slot_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// apply one accepted word to the predicted map and return the result it owes
	function automatic rsp_t apply_to_map(input req_t word);
		rsp_t res;
		int   w;
		int   b;
		res.status   = STATUS_FULL;
		res.slot_out = '0;
		if (word.func == FUNC_ALLOC) begin
			// first word with a clear bit wins, lowest clear bit within it
			for (w = 0; w < MAP_WORDS && res.status == STATUS_FULL; w++) begin
				if (slot_bits[w] != '1) begin
					b = 0;
					while (slot_bits[w][b])
						b++;
					slot_bits[w][b] = 1'b1;
					res.status      = STATUS_DONE;
					res.slot_out    = SLOT_W'(w * WORD_W + b);
				end
			end
		end else begin
			// release clears the bit (no effect if already free or past the map)
			w = int'(word.slot_index) / WORD_W;
			b = int'(word.slot_index) % WORD_W;
			if (w < MAP_WORDS)
				slot_bits[w][b] = 1'b0;
			res.status   = STATUS_DONE;
			res.slot_out = word.slot_index;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// offer one word; the sender runs in bursts with random gaps in between.
	// prediction happens here, right at acceptance, so the map the random part
	// looks at is always current
	task automatic offer_word(input req_t word, input logic typed, input rsp_t want);
		rsp_t predicted;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
			                                         : $urandom_range(1, 24);
		end
		req_valid <= 1'b1;
		req       <= word;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		burst_left--;
		predicted = apply_to_map(word);
		results_due.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// wait until every predicted result has come back
	task automatic wait_results_in();
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// sender side: reset, directed plan, full drain, random mix, final drain
	initial begin : stimulus
		req_t               word;
		mix_t               mix;
		int                 mix_left;
		int                 alloc_pct;
		int                 k;
		logic [SLOT_W-1:0]  probe;
		mix_left = 0;
		mix      = MIX_EVEN;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan; allocates carry random slot_index since it is ignored
		for (int row = 0; row < PLAN_ROWS; row++) begin
			for (int n = 0; n < int'(PLAN[row].count); n++) begin
				word.func       = PLAN[row].func;
				word.slot_index = (PLAN[row].func == FUNC_ALLOC) ? SLOT_W'($urandom)
				                                                  : PLAN[row].slot;
				offer_word(word, PLAN[row].typed, PLAN[row].want);
			end
		end

		// sender goes quiet until everything owed has come back
		req_valid <= 1'b0;
		burst_left = 0;
		wait_results_in();

		// random part: phases that lean toward filling, draining or an even mix,
		// so the map swings between empty and full and full statuses show up
		while (items_sent < ITEMS) begin
			if (mix_left == 0) begin
				mix      = mix_t'($urandom_range(0, 2));
				mix_left = $urandom_range(16, 160);
			end
			mix_left--;
			// halfway through, ask the receiver for its long hold-off
			if (!hold_req && items_sent >= ITEMS / 2)
				hold_req <= 1'b1;
			case (mix)
				MIX_FILL:  alloc_pct = 90;
				MIX_DRAIN: alloc_pct = 15;
				default:   alloc_pct = 50;
			endcase
			word.func       = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_RELEASE;
			word.slot_index = SLOT_W'($urandom_range(0, 255));
			if (word.func == FUNC_RELEASE && $urandom_range(0, 3) != 0) begin
				// mostly release a slot that is actually taken: walk up from a
				// random start to the next set bit (wraps at 256)
				probe = word.slot_index;
				for (k = 0; k < SLOTS && !slot_bits[int'(probe) / WORD_W][int'(probe) % WORD_W];
				     k++)
					probe = probe + 1'b1;
				word.slot_index = probe;
			end
			offer_word(word, 1'b0, '0);
		end

		req_valid <= 1'b0;
		wait_results_in();
		// a little longer in case the block sends something nobody asked for
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// receiver side: changes its stall pattern at random intervals, and once
	// holds off for a long stretch so the output register fills and req_stall rises
	initial begin : receiver
		rx_mode_t mode;
		int       left;
		int       phase;
		mode  = RX_FLOW;
		left  = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(8, 80);
			end
			left--;
			phase++;
			case (mode)
				RX_FLOW:      rsp_stall <= 1'b0;
				RX_RANDOM:    rsp_stall <= ($urandom_range(0, 2) == 0);
				RX_ALTERNATE: rsp_stall <= phase[0];
				default:      rsp_stall <= (phase[1:0] != 2'd3);
			endcase
		end
	end

	// every accepted result word must match the oldest prediction, field by field
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("result word with nothing expected, slot_out",
				                int'(rsp.slot_out), 0);
			end else begin
				want = results_due.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.slot_out !== want.slot_out)
					report_mismatch("slot_out", int'(rsp.slot_out), int'(want.slot_out));
			end
		end
	end

	// watchdog: too long without a handshake on either side ends the run
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
`default_nettype wire
